[sv/ppbs_pkg.sv]
`default_nettype none

package ppbs_pkg;

  localparam int unsigned PIXEL_W = 32;
  localparam int unsigned COUNT_W = 25;
  localparam int unsigned SUM_W   = 32;
  localparam int unsigned GRAY_W  = 8;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_first;
    logic [PIXEL_W-1:0] pixel_second;
    logic               frame_end;
  } pair_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] pixel_total;
    logic [COUNT_W-1:0] identical_count;
    logic [COUNT_W-1:0] brighter_count;
    logic [COUNT_W-1:0] darker_count;
    logic [SUM_W-1:0]   gray_sum_first;
    logic [SUM_W-1:0]   gray_sum_second;
  } stats_item_t;

endpackage

`default_nettype wire

[sv/ppbs_if.sv]
`default_nettype none

interface ppbs_pair_if
  import ppbs_pkg::*;
();
  logic       valid;
  logic       ready;
  pair_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ppbs_stats_if
  import ppbs_pkg::*;
();
  logic        valid;
  logic        ready;
  stats_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[sv/pixel_pair_brightness_stats_core.sv]
`default_nettype none

// Compares two images one co-located ARGB pixel pair per transaction and
// reports, on the pair flagged frame_end, the number of pairs, the identical,
// brighter and darker counts and the gray-level sums of both images; all
// statistics then restart from zero for the next image. Unless the input is
// stalled, a pair is taken in every cycle: one input register feeds the
// accumulator update, so the sustained rate is one pair per clock. The
// result for a frame is registered in the output register after its last
// pair has passed the input register and waits there without blocking
// further pairs; only a second frame end arriving while the previous result
// is still untaken stalls the input. Counters saturate at the smaller of
// MAX_PIXELS and 2^25 - 1, sums at 2^32 - 1.
module pixel_pair_brightness_stats_core
  import ppbs_pkg::*;
#(
  parameter int unsigned MAX_PIXELS = 16777216
) (
  input  wire           clk,
  input  wire           rst,
  ppbs_pair_if.sink     pairs,
  ppbs_stats_if.source  stats
);

  localparam logic [COUNT_W-1:0] COUNT_ALL_ONES = {COUNT_W{1'b1}};
  localparam logic [COUNT_W-1:0] CNT_CAP =
    (MAX_PIXELS > 32'(COUNT_ALL_ONES)) ? COUNT_ALL_ONES : COUNT_W'(MAX_PIXELS);

  function automatic logic [GRAY_W-1:0] gray_of(input logic [PIXEL_W-1:0] argb);
    logic [12:0] r;
    logic [12:0] g;
    logic [12:0] b;
    logic [12:0] weighted;
    r = {5'd0, argb[23:16]};
    g = {5'd0, argb[15:8]};
    b = {5'd0, argb[7:0]};
    weighted = r * 13'd11 + (g << 4) + b * 13'd5;
    return weighted[12:5];
  endfunction

  function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] c);
    return (c >= CNT_CAP) ? CNT_CAP : c + COUNT_W'(1);
  endfunction

  function automatic logic [SUM_W-1:0] add_sat(input logic [SUM_W-1:0] acc,
                                               input logic [GRAY_W-1:0] v);
    logic [SUM_W:0] s;
    s = {1'b0, acc} + (SUM_W+1)'(v);
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

  logic        s1_valid;
  pair_item_t  s1_item;

  logic [COUNT_W-1:0] pair_counter;
  logic [COUNT_W-1:0] identical_counter;
  logic [COUNT_W-1:0] brighter_counter;
  logic [COUNT_W-1:0] darker_counter;
  logic [SUM_W-1:0]   gray_accum_first;
  logic [SUM_W-1:0]   gray_accum_second;

  logic [GRAY_W-1:0]  gray_first;
  logic [GRAY_W-1:0]  gray_second;
  logic               same_word;
  logic               first_brighter;
  stats_item_t        stats_next;

  logic        out_valid;
  stats_item_t out_data;

  logic out_free;
  logic s1_fire;

  assign out_free = !out_valid || stats.ready;
  assign s1_fire  = s1_valid && (!s1_item.frame_end || out_free);
  assign pairs.ready = !s1_valid || s1_fire;

  assign stats.valid = out_valid;
  assign stats.data  = out_data;

  always_comb begin
    gray_first     = gray_of(s1_item.pixel_first);
    gray_second    = gray_of(s1_item.pixel_second);
    same_word      = s1_item.pixel_first == s1_item.pixel_second;
    first_brighter = gray_first > gray_second;

    stats_next.pixel_total     = bump(pair_counter);
    stats_next.identical_count = same_word ? bump(identical_counter) : identical_counter;
    stats_next.brighter_count  = (!same_word && first_brighter) ?
                                 bump(brighter_counter) : brighter_counter;
    stats_next.darker_count    = (!same_word && !first_brighter) ?
                                 bump(darker_counter) : darker_counter;
    stats_next.gray_sum_first  = add_sat(gray_accum_first, gray_first);
    stats_next.gray_sum_second = add_sat(gray_accum_second, gray_second);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pairs.ready) begin
      s1_valid <= pairs.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pairs.ready && pairs.valid) begin
      s1_item <= pairs.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_counter      <= '0;
      identical_counter <= '0;
      brighter_counter  <= '0;
      darker_counter    <= '0;
      gray_accum_first  <= '0;
      gray_accum_second <= '0;
    end else if (s1_fire) begin
      if (s1_item.frame_end) begin
        pair_counter      <= '0;
        identical_counter <= '0;
        brighter_counter  <= '0;
        darker_counter    <= '0;
        gray_accum_first  <= '0;
        gray_accum_second <= '0;
      end else begin
        pair_counter      <= stats_next.pixel_total;
        identical_counter <= stats_next.identical_count;
        brighter_counter  <= stats_next.brighter_count;
        darker_counter    <= stats_next.darker_count;
        gray_accum_first  <= stats_next.gray_sum_first;
        gray_accum_second <= stats_next.gray_sum_second;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_item.frame_end) begin
      out_valid <= 1'b1;
    end else if (stats.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_item.frame_end) begin
      out_data <= stats_next;
    end
  end

endmodule

`default_nettype wire
